[rtl/sbs_pkg.sv]
// Shared constants, codes and types for the byte substring search block.
package sbs_pkg;

  // Needle capacity and derived widths
  localparam int unsigned MAX_NEEDLE = 16;
  localparam int unsigned CNT_W      = $clog2(MAX_NEEDLE + 1);
  localparam int unsigned HAY_W      = 31;
  localparam int unsigned IDX_W      = 32;

  // Item kinds carried on in_tuser
  localparam logic [1:0] KIND_NEEDLE   = 2'd0;
  localparam logic [1:0] KIND_HAYSTACK = 2'd1;
  localparam logic [1:0] KIND_END      = 2'd2;

  // Match index reported when there is no occurrence
  localparam logic [IDX_W-1:0] NO_MATCH = '1;

  // Shift controls common to every cell of the chain
  typedef struct packed {
    logic needle_shift;
    logic hay_shift;
  } sbs_ctl_t;

  // One search result
  typedef struct packed {
    logic             needle_truncated;
    logic [IDX_W-1:0] match_index;
    logic             found;
  } sbs_result_t;

endpackage

[rtl/sbs_cell.sv]
// One compare cell: holds a needle byte and a window byte, passes both along the chain.
module sbs_cell (
  input  logic              clk,
  input  sbs_pkg::sbs_ctl_t ctl,
  input  logic              active,
  input  logic [7:0]        needle_in,
  input  logic [7:0]        hay_in,
  output logic [7:0]        needle_q,
  output logic [7:0]        hay_q,
  output logic              hit
);
  import sbs_pkg::*;

  logic [7:0] needle_r;
  logic [7:0] recent_r;

  // Advance the needle byte on load, the window byte on a haystack beat
  always_ff @(posedge clk) begin
    if (ctl.needle_shift) begin
      needle_r <= needle_in;
    end
    if (ctl.hay_shift) begin
      recent_r <= hay_in;
    end
  end

  // Compare against the window byte this cell takes on the current beat
  assign hit      = !active || (needle_r == hay_in);
  assign needle_q = needle_r;
  assign hay_q    = recent_r;

endmodule

[rtl/sbs_out_buf.sv]
// Result register with a skid stage so the input side never waits on out_tready directly.
module sbs_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sbs_pkg::sbs_result_t push_data,
  output logic                 push_ready,
  output logic                 out_valid,
  output sbs_pkg::sbs_result_t out_data,
  input  logic                 out_ready
);
  import sbs_pkg::*;

  logic        out_valid_r;
  logic        skid_valid_r;
  sbs_result_t out_data_r;
  sbs_result_t skid_data_r;
  logic        out_free;

  assign out_free = !out_valid_r || out_ready;

  // Control: refill the output from the skid first, else from a new push
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

endmodule

[rtl/byte_substring_search.sv]
// Top level: streamed first-occurrence substring search over a chain of compare cells.
//
//  channel | ports                         | contents
//  --------+-------------------------------+------------------------------------------
//  input   | in_tvalid/in_tready           | tuser[1:0] kind, tdata[7:0] data_byte
//  result  | out_tvalid/out_tready         | tuser[0] found, tuser[1] needle_truncated,
//          |                               | tdata[31:0] match_index
//  config  | cfg_wr_en/cfg_wr_data         | start_position (signed 32 bits)
//
// One beat per cycle while in_tready is high: each needle or haystack byte is folded
// into the cell chain in the cycle it is taken; the end beat's result is registered.
// Synchronous active-low reset clears counts and flags; no clearing pass.
// A stalled result sits in the output register, a second one in the skid stage;
// in_tready drops only while the skid stage holds a result.
module byte_substring_search (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic [1:0]  in_tuser,    // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] match_index
  output logic [1:0]  out_tuser,   // [0] found, [1] needle_truncated
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data  // start_position
);
  import sbs_pkg::*;

  logic [IDX_W-1:0] start_r;
  logic [CNT_W-1:0] needle_count_r;
  logic             overflow_r;
  logic [HAY_W-1:0] hay_count_r;
  logic             match_seen_r;
  logic [HAY_W-1:0] first_match_r;

  logic             take;
  logic             is_needle;
  logic             is_hay;
  logic             is_end;
  logic             needle_room;
  logic             hay_room;
  sbs_ctl_t         ctl;

  logic [7:0]            needle_link [MAX_NEEDLE+1];
  logic [7:0]            hay_link    [MAX_NEEDLE+1];
  logic [MAX_NEEDLE-1:0] hit;

  logic [HAY_W-1:0] start_off;
  logic [IDX_W-1:0] pos_plus1;
  logic [IDX_W-1:0] start_plus_n;
  logic [IDX_W-1:0] first_pos;
  logic             match_now;
  logic [HAY_W-1:0] empty_idx;
  sbs_result_t      result;
  sbs_result_t      out_res;

  // Decode the beat
  assign take        = in_tvalid && in_tready;
  assign is_needle   = take && (in_tuser == KIND_NEEDLE);
  assign is_hay      = take && (in_tuser == KIND_HAYSTACK);
  assign is_end      = take && (in_tuser == KIND_END);
  assign needle_room = (needle_count_r < CNT_W'(MAX_NEEDLE));
  assign hay_room    = (hay_count_r != '1);

  assign ctl.needle_shift = is_needle && needle_room;
  assign ctl.hay_shift    = is_hay && hay_room;

  // Cell chain: newest needle byte and newest haystack byte enter at cell 0
  assign needle_link[0] = in_tdata;
  assign hay_link[0]    = in_tdata;

  for (genvar j = 0; j < MAX_NEEDLE; j++) begin : g_cell
    sbs_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .active    (CNT_W'(j) < needle_count_r),
      .needle_in (needle_link[j]),
      .hay_in    (hay_link[j]),
      .needle_q  (needle_link[j+1]),
      .hay_q     (hay_link[j+1]),
      .hit       (hit[j])
    );
  end

  // Window check: the occurrence must start at or after the start offset
  assign start_off    = start_r[IDX_W-1] ? '0 : start_r[HAY_W-1:0];
  assign pos_plus1    = {1'b0, hay_count_r} + IDX_W'(1);
  assign start_plus_n = {1'b0, start_off} + IDX_W'(needle_count_r);
  assign first_pos    = pos_plus1 - IDX_W'(needle_count_r);
  assign match_now    = ctl.hay_shift && (needle_count_r != '0) && !match_seen_r &&
                        (pos_plus1 >= start_plus_n) && (&hit);

  // Build the end result
  assign empty_idx = (start_off > hay_count_r) ? hay_count_r : start_off;

  always_comb begin
    result.needle_truncated = overflow_r;
    if (needle_count_r == '0) begin
      result.found       = 1'b1;
      result.match_index = {1'b0, empty_idx};
    end else if (match_seen_r) begin
      result.found       = 1'b1;
      result.match_index = {1'b0, first_match_r};
    end else begin
      result.found       = 1'b0;
      result.match_index = NO_MATCH;
    end
  end

  // Hold the start register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else if (cfg_wr_en) begin
      start_r <= cfg_wr_data;
    end
  end

  // Advance counts and flags; drop everything on the end beat
  always_ff @(posedge clk) begin
    if (!rst_n || is_end) begin
      needle_count_r <= '0;
      overflow_r     <= 1'b0;
      hay_count_r    <= '0;
      match_seen_r   <= 1'b0;
      first_match_r  <= '0;
    end else begin
      if (ctl.needle_shift) begin
        needle_count_r <= needle_count_r + CNT_W'(1);
      end
      if (is_needle && !needle_room) begin
        overflow_r <= 1'b1;
      end
      if (ctl.hay_shift) begin
        hay_count_r <= hay_count_r + HAY_W'(1);
      end
      if (match_now) begin
        match_seen_r  <= 1'b1;
        first_match_r <= first_pos[HAY_W-1:0];
      end
    end
  end

  // Output register and skid stage
  sbs_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (is_end),
    .push_data  (result),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_res),
    .out_ready  (out_tready)
  );

  assign out_tdata = out_res.match_index;
  assign out_tuser = {out_res.needle_truncated, out_res.found};

`ifndef NO_ASSERTIONS
  // Input side stalls only while two results are queued
  a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with no result pending");

  // Needle count never passes the cell count
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    needle_count_r <= CNT_W'(MAX_NEEDLE))
    else $error("needle count beyond capacity");

  // A recorded match implies a needle and a start inside the haystack seen
  a_match_sane: assert property (@(posedge clk) disable iff (!rst_n)
    match_seen_r |-> (needle_count_r != '0) && (first_match_r < hay_count_r))
    else $error("inconsistent match record");

  // The end beat leaves the search state cleared
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    is_end |=> (needle_count_r == '0) && !match_seen_r && (hay_count_r == '0))
    else $error("search state not cleared after end beat");
`endif

endmodule
